@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_mem, spq_ctrl and sorted_priority_queue_core.
`timescale 1ns / 1ps

package spq_pkg;

    // Default number of entries in the queue.
    localparam int SPQ_DEPTH = 16;

    // Operation codes carried on the kind field.
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Controller sequencing.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HREQ,
        ST_HRESP
    } state_t;

    // Entry memory strobes.
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    // One finished result, handed to the output register.
    typedef struct packed {
        logic        ok;
        logic [3:0]  position;
        logic [4:0]  length;
        logic        head_valid;
        logic [31:0] head_value;
    } res_t;

endpackage

@@ src/spq_mem.sv @@
// Entry store: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_mem #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  spq_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     waddr,
    input  logic [31:0]       wdata,
    input  logic [AW-1:0]     raddr,
    output logic [31:0]       rdata
);
    import spq_pkg::*;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/spq_ctrl.sv @@
// Queue sequencer: walks the entry memory one word per cycle to insert,
// remove or find, then reads the head. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [31:0]       value,
    output spq_pkg::res_t     res,
    output logic              res_valid,
    input  logic              res_ready,
    output spq_pkg::mem_ctl_t mem_ctl,
    output logic [AW-1:0]     mem_waddr,
    output logic [31:0]       mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  logic [31:0]       mem_rdata
);
    import spq_pkg::*;

    state_t        state_reg, state_next;
    kind_t         op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;   // next index to issue
    logic [CW-1:0] tag_reg, tag_next;   // index of the word in flight; for insert, the slot it moves to
    logic          more_reg, more_next;
    logic          rv_reg, rv_next;
    logic          found_reg, found_next;
    logic [AW-1:0] pos_reg, pos_next;

    logic   accept, start_scan, fin, full, last;
    logic   st_idle, st_scan, st_hreq;
    kind_t  kind_in;

    assign kind_in = kind_t'(kind);
    assign accept  = in_valid && st_idle;
    assign full    = (cnt_reg == CW'(DEPTH));
    assign last    = (tag_reg == cnt_reg - CW'(1));

    always_comb
    begin
        start_scan = 1'b0;
        case (kind_in) inside
            KIND_INSERT:           start_scan = !full;
            KIND_REMOVE, KIND_FIND: start_scan = (cnt_reg != '0);
            default:               start_scan = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = start_scan ? ST_SCAN : ST_HREQ;
                end
            end
            ST_SCAN:
            begin
                if (fin)
                begin
                    state_next = ST_HREQ;
                end
            end
            ST_HREQ:  state_next = ST_HRESP;
            ST_HRESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // State decode
    always_comb
    begin
        st_idle   = 1'b0;
        st_scan   = 1'b0;
        st_hreq   = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:  st_idle   = 1'b1;
            ST_SCAN:  st_scan   = 1'b1;
            ST_HREQ:  st_hreq   = 1'b1;
            ST_HRESP: res_valid = 1'b1;
            default:  st_idle   = 1'b0;
        endcase
    end

    assign in_stall = !st_idle;

    // Datapath
    always_comb
    begin
        op_next    = op_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        tag_next   = tag_reg;
        more_next  = more_reg;
        rv_next    = 1'b0;
        found_next = found_reg;
        pos_next   = pos_reg;
        mem_ctl    = '0;
        mem_waddr  = '0;
        mem_wdata  = val_reg;
        mem_raddr  = '0;
        fin        = 1'b0;

        if (accept)
        begin
            op_next    = kind_in;
            val_next   = value;
            pos_next   = '0;
            more_next  = start_scan;
            // an insert that starts always stores
            found_next = start_scan && (kind_in == KIND_INSERT);
            ptr_next   = (kind_in == KIND_INSERT) ? cnt_reg : '0;
        end

        if (st_scan)
        begin
            // consume the word read last cycle
            if (rv_reg)
            begin
                case (op_reg)
                    KIND_INSERT:
                    begin
                        // walking from the tail: shift down while value >= entry
                        mem_ctl.we = 1'b1;
                        mem_waddr  = AW'(tag_reg);
                        if (tag_reg == '0 || $signed(val_reg) < $signed(mem_rdata))
                        begin
                            mem_wdata = val_reg;
                            fin       = 1'b1;
                        end
                        else
                        begin
                            mem_wdata = mem_rdata;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            mem_ctl.we = 1'b1;
                            mem_waddr  = AW'(tag_reg - CW'(1));
                            mem_wdata  = mem_rdata;
                        end
                        else if (mem_rdata == val_reg)
                        begin
                            found_next = 1'b1;
                            pos_next   = AW'(tag_reg);
                        end
                        fin = last;
                    end
                    default:
                    begin
                        if (mem_rdata == val_reg)
                        begin
                            found_next = 1'b1;
                            pos_next   = AW'(tag_reg);
                            fin        = 1'b1;
                        end
                        else
                        begin
                            fin = last;
                        end
                    end
                endcase
            end

            // issue the next read
            if (more_reg && !fin)
            begin
                rv_next  = 1'b1;
                tag_next = ptr_reg;
                if (op_reg == KIND_INSERT)
                begin
                    // index zero has no word above it: no read, value lands there
                    mem_ctl.re = (ptr_reg != '0);
                    mem_raddr  = AW'(ptr_reg - CW'(1));
                    ptr_next   = ptr_reg - CW'(1);
                    more_next  = (ptr_reg != '0);
                end
                else
                begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = AW'(ptr_reg);
                    ptr_next   = ptr_reg + CW'(1);
                    more_next  = (CW'(ptr_reg + CW'(1)) < cnt_reg);
                end
            end

            if (fin)
            begin
                more_next = 1'b0;
            end
        end

        if (st_hreq)
        begin
            mem_ctl.re = 1'b1;
            mem_raddr  = '0;
            if (found_reg && op_reg == KIND_INSERT)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else if (found_reg && op_reg == KIND_REMOVE)
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_comb
    begin
        res.ok         = found_reg;
        res.position   = (op_reg == KIND_FIND && found_reg) ? 4'(pos_reg) : 4'd0;
        res.length     = 5'(cnt_reg);
        res.head_valid = (cnt_reg != '0);
        res.head_value = (cnt_reg != '0) ? mem_rdata : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= KIND_NONE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            tag_reg   <= '0;
            more_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            tag_reg   <= tag_next;
            more_reg  <= more_next;
            rv_reg    <= rv_next;
            found_reg <= found_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ src/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: entry memory, sequencer and
// result register. Depends on spq_pkg, spq_mem, spq_ctrl.
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// in      | sink      | in_valid / in_stall   | kind, value
// out     | source    | out_valid / out_stall | ok, position, length, head_valid, head_value
//
// A transaction that needs a walk reads the entry memory one word per cycle
// through its single read port: remove reads every entry, find reads up to the
// first match, and insert reads from the tail, moving down one slot each
// entry not greater than its value. No walk is needed for an insert into a
// full queue, a remove or find on an empty queue, or an unused code. The
// sequencer then reads the head and offers the result; the output register
// loads it when it can, and the next transaction is accepted in the cycle after.
// Reset clears the entry count and control state, not memory; words past it go unused.
// A stalled result sits in the output register while the next transaction is
// accepted and processed; the sequencer waits only if its next result is ready
// before the previous one has left.

module sorted_priority_queue_core #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [3:0]  position,
    output logic [4:0]  length,
    output logic        head_valid,
    output logic [31:0] head_value
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    res_t res;
    logic res_valid;
    logic res_ready;

    res_t res_reg;
    logic out_valid_reg, out_valid_next;

    spq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    spq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .mem_ctl   (mem_ctl),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Output register loads when empty or draining this cycle.
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = res_reg.ok;
    assign position   = res_reg.position;
    assign length     = res_reg.length;
    assign head_valid = res_reg.head_valid;
    assign head_value = res_reg.head_value;

endmodule

@@ src/spq_checker.sv @@
// Port-level checks for sorted_priority_queue_core, bound onto the top level.
// Depends on sorted_priority_queue_core only through the bind below.
`timescale 1ns / 1ps

module spq_props (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        ok,
    input logic [3:0]  position,
    input logic [4:0]  length,
    input logic        head_valid,
    input logic [31:0] head_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(head_value) && $stable(length))
        else $error("stalled result changed");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_valid |-> length == 5'd0)
        else $error("empty queue reports nonzero length");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_valid |-> head_value == 32'd0)
        else $error("empty queue reports nonzero head");

    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && position != 4'd0 |-> ok)
        else $error("nonzero position without a match");

endmodule

bind sorted_priority_queue_core spq_props u_spq_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .position   (position),
    .length     (length),
    .head_valid (head_valid),
    .head_value (head_value)
);
